/* rtl/core/nca_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nca_pkg
// Shared types, constants and round functions of the keyed NLFSR auth core.
// -----------------------------------------------------------------------------
package nca_pkg;

  localparam int unsigned RegW    = 48;
  localparam int unsigned WordW   = 32;
  localparam int unsigned KeyW    = 48;
  localparam int unsigned Rounds  = 32;

  localparam logic [15:0]     LutA   = 16'h2C79;
  localparam logic [15:0]     LutB   = 16'h6671;
  localparam logic [31:0]     LutTop = 32'h7907287B;
  localparam logic [RegW-1:0] FbTaps = 48'hB38083220073;

  // Data carried from cell to cell. aux holds the remaining IV bits during
  // init rounds and the collected auth bits during output rounds.
  typedef struct packed {
    logic [RegW-1:0]  r;
    logic [WordW-1:0] aux;
    logic [WordW-1:0] exp_word;
  } cell_data_t;

  function automatic logic lut4(input logic [15:0] tbl, input logic a, input logic b,
                                input logic c, input logic d);
    logic [3:0] idx;
    idx = {a, b, c, d};
    return tbl[idx];
  endfunction

  function automatic logic nl_out(input logic [RegW-1:0] r);
    logic [4:0] g;
    g[0] = lut4(LutA, r[41], r[42], r[44], r[45]);
    g[1] = lut4(LutB, r[32], r[33], r[35], r[39]);
    g[2] = lut4(LutB, r[21], r[24], r[26], r[30]);
    g[3] = lut4(LutB, r[14], r[16], r[18], r[19]);
    g[4] = lut4(LutA, r[1], r[3], r[4], r[13]);
    return LutTop[g];
  endfunction

  function automatic logic lin_out(input logic [RegW-1:0] r);
    return ^(r & FbTaps);
  endfunction

endpackage

/* rtl/core/nca_in_if.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nca_in_if
// Input channel: one candidate word per handshake.
// -----------------------------------------------------------------------------
interface nca_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] tag_id;
  logic [3:0]  button_code;
  logic [9:0]  control_word;
  logic [17:0] epoch_count;
  logic [31:0] expected_word;

  modport source (
    output valid, tag_id, button_code, control_word, epoch_count, expected_word,
    input  ready
  );
  modport sink (
    input  valid, tag_id, button_code, control_word, epoch_count, expected_word,
    output ready
  );
endinterface

/* rtl/core/nca_out_if.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nca_out_if
// Output channel: computed auth word and match flag.
// -----------------------------------------------------------------------------
interface nca_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] auth_word;
  logic        matches_res;

  modport source (
    output valid, auth_word, matches_res,
    input  ready
  );
  modport sink (
    input  valid, auth_word, matches_res,
    output ready
  );
endinterface

/* rtl/core/nca_init_cell.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nca_init_cell
// One init round: shift in IV bit ^ key bit ^ filter output.
// -----------------------------------------------------------------------------
module nca_init_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                key_bit_i,
  input  logic                valid_i,
  input  nca_pkg::cell_data_t data_i,
  output logic                valid_o,
  output nca_pkg::cell_data_t data_o
);

  logic                valid_q;
  nca_pkg::cell_data_t data_q, data_d;
  logic                fb;

  always_comb begin
    fb              = data_i.aux[nca_pkg::WordW-1] ^ key_bit_i ^ nca_pkg::nl_out(data_i.r);
    data_d.r        = {data_i.r[nca_pkg::RegW-2:0], fb};
    data_d.aux      = {data_i.aux[nca_pkg::WordW-2:0], 1'b0};
    data_d.exp_word = data_i.exp_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/nca_out_cell.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nca_out_cell
// One output round: collect the filter bit, shift in linear feedback.
// -----------------------------------------------------------------------------
module nca_out_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  nca_pkg::cell_data_t data_i,
  output logic                valid_o,
  output nca_pkg::cell_data_t data_o
);

  logic                valid_q;
  nca_pkg::cell_data_t data_q, data_d;

  always_comb begin
    data_d.r        = {data_i.r[nca_pkg::RegW-2:0], nca_pkg::lin_out(data_i.r)};
    data_d.aux      = {data_i.aux[nca_pkg::WordW-2:0], nca_pkg::nl_out(data_i.r)};
    data_d.exp_word = data_i.exp_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/nlfsr_cipher_auth_word_core.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nlfsr_cipher_auth_word_core
// Keyed NLFSR auth word generator and checker, one round per cell.
// -----------------------------------------------------------------------------
// The core takes one candidate word per clock while the output is taken
// and returns its auth word and match flag through a chain of 32 init cells
// followed by 32 output cells, each cell doing one register round and
// passing its state to the next cell whenever the chain moves. The first
// cell loads at the accepting edge, and the result comes out of the last
// output cell's register. When the output word is not taken the whole chain
// holds, and a one-word input buffer still takes one more word. Write the key
// only while no word is in flight.
module nlfsr_cipher_auth_word_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [47:0]  cfg_wdata_i,
  nca_in_if.sink       in_i,
  nca_out_if.source    out_o
);

  localparam int unsigned NumCells = 2 * nca_pkg::Rounds;

  logic [nca_pkg::KeyW-1:0] key_q;

  logic                valid_c [NumCells+1];
  nca_pkg::cell_data_t data_c  [NumCells+1];

  logic                skid_valid_q, skid_valid_d;
  nca_pkg::cell_data_t skid_data_q, load_data;
  logic                in_fire, en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q <= cfg_wdata_i;
    end
  end

  assign en       = !valid_c[NumCells] || out_o.ready;
  assign in_i.ready = !skid_valid_q;
  assign in_fire  = in_i.valid && !skid_valid_q;

  always_comb begin
    load_data.r        = {in_i.tag_id, key_q[15:0]};
    load_data.aux      = {in_i.epoch_count, in_i.control_word, in_i.button_code};
    load_data.exp_word = in_i.expected_word;
  end

  // Drain the buffer when the chain moves, fill it when a word arrives on a stall.
  always_comb begin
    if (en) begin
      skid_valid_d = 1'b0;
    end else begin
      skid_valid_d = skid_valid_q || in_fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_fire) begin
      skid_data_q <= load_data;
    end
  end

  assign valid_c[0] = skid_valid_q || in_fire;
  assign data_c[0]  = skid_valid_q ? skid_data_q : load_data;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    if (i < nca_pkg::Rounds) begin : g_init
      nca_init_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .en_i      (en),
        .key_bit_i (key_q[nca_pkg::KeyW-1-i]),
        .valid_i   (valid_c[i]),
        .data_i    (data_c[i]),
        .valid_o   (valid_c[i+1]),
        .data_o    (data_c[i+1])
      );
    end else begin : g_out
      nca_out_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (valid_c[i]),
        .data_i  (data_c[i]),
        .valid_o (valid_c[i+1]),
        .data_o  (data_c[i+1])
      );
    end
  end

  assign out_o.valid       = valid_c[NumCells];
  assign out_o.auth_word   = data_c[NumCells].aux;
  assign out_o.matches_res = (data_c[NumCells].aux == data_c[NumCells].exp_word);

  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(!en))
    else $error("input buffer filled while chain was moving");

  a_entry_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && valid_c[0]) |=> valid_c[1])
    else $error("word lost at chain entry");

  a_stall_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !en) |=> skid_valid_q)
    else $error("word accepted on stall not buffered");

endmodule

/* tb/tb_nlfsr_cipher_auth_word_core.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_nlfsr_cipher_auth_word_core
// Self-checking bench for the keyed NLFSR auth word core. A directed table
// covers field extremes, key extremes, match and mismatch. Random candidates
// follow under four flow-control profiles, each with a fresh key. Every word
// out is checked against a bit-true model of the 64 rounds or a typed value.
// -----------------------------------------------------------------------------
module tb_nlfsr_cipher_auth_word_core;

  localparam int unsigned ChainLat   = 64;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRows    = 19;
  localparam int unsigned PhaseWords = 263;

  typedef struct packed {
    logic [31:0] tag;
    logic [3:0]  button;
    logic [9:0]  control;
    logic [17:0] epoch;
    logic [31:0] rx_word;
  } cand_t;

  typedef struct packed {
    logic [31:0] auth;
    logic        matched;
  } auth_t;

  typedef struct {
    logic [47:0] key;
    logic [31:0] tag;
    logic [3:0]  button;
    logic [9:0]  control;
    logic [17:0] epoch;
    logic [31:0] rx_word;
    bit          hit;
    bit          typed_in;
    logic [31:0] typed_auth;
    logic        typed_match;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [47:0] cfg_wdata;

  nca_in_if  in_if ();
  nca_out_if out_if ();

  nlfsr_cipher_auth_word_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  auth_t       auth_q[$];
  logic [47:0] cur_key;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          errors = 0;
  int          words_sent;
  int          words_checked = 0;
  int          hits_seen = 0;
  int          keys_loaded;
  int unsigned cycles = 0;
  row_t        dir_rows [NumRows];

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Bit-true model of the cipher rounds
  // ---------------------------------------------------------------------------
  function automatic logic filter_bit(input logic [47:0] s);
    logic [4:0] sel;
    sel[0] = nca_pkg::LutA[{s[41], s[42], s[44], s[45]}];
    sel[1] = nca_pkg::LutB[{s[32], s[33], s[35], s[39]}];
    sel[2] = nca_pkg::LutB[{s[21], s[24], s[26], s[30]}];
    sel[3] = nca_pkg::LutB[{s[14], s[16], s[18], s[19]}];
    sel[4] = nca_pkg::LutA[{s[1], s[3], s[4], s[13]}];
    return nca_pkg::LutTop[sel];
  endfunction

  function automatic auth_t hop_auth(input logic [47:0] key, input cand_t c);
    logic [47:0] s;
    logic [31:0] iv;
    logic        fb;
    auth_t       res;
    iv = {c.epoch, c.control, c.button};
    s  = {c.tag, key[15:0]};
    res.auth = '0;
    for (int i = 0; i < 32; i++) begin
      fb = iv[31-i] ^ key[47-i] ^ filter_bit(s);
      s  = {s[46:0], fb};
    end
    for (int i = 0; i < 32; i++) begin
      res.auth = {res.auth[30:0], filter_bit(s)};
      fb = 1'b0;
      for (int b = 0; b < 48; b++) fb ^= s[b] & nca_pkg::FbTaps[b];
      s = {s[46:0], fb};
    end
    res.matched = (res.auth == c.rx_word);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drive side: called and returning at a falling edge
  // ---------------------------------------------------------------------------
  task automatic push_word(input cand_t c, input auth_t gold);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         = 1'b1;
    in_if.tag_id        = c.tag;
    in_if.button_code   = c.button;
    in_if.control_word  = c.control;
    in_if.epoch_count   = c.epoch;
    in_if.expected_word = c.rx_word;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    auth_q.push_back(gold);
    words_sent++;
    // keep valid up; the next call decides whether to drop it
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_if.valid = 1'b0;
    while (auth_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic load_key(input logic [47:0] k);
    cfg_we    = 1'b1;
    cfg_wdata = k;
    @(negedge clk_i);
    cfg_we  = 1'b0;
    cur_key = k;
    keys_loaded++;
  endtask

  // ---------------------------------------------------------------------------
  // Receive side
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    auth_t gold;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (auth_q.size() == 0) begin
        errors++;
        $display("%0t: word with nothing pending: auth=%h match=%b", $time,
                 out_if.auth_word, out_if.matches_res);
      end else begin
        gold = auth_q.pop_front();
        words_checked++;
        if (out_if.matches_res === 1'b1) hits_seen++;
        if (out_if.auth_word !== gold.auth) begin
          errors++;
          $display("%0t: auth_word expected %h actual %h", $time, gold.auth,
                   out_if.auth_word);
        end
        if (out_if.matches_res !== gold.matched) begin
          errors++;
          $display("%0t: matches_res expected %b actual %b", $time, gold.matched,
                   out_if.matches_res);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout, %0d words still pending", $time, auth_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    cand_t       c;
    auth_t       gold;
    int          pick;
    logic [63:0] rkey;

    words_sent    = 0;
    keys_loaded   = 0;
    cur_key       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_if.valid         = 1'b0;
    in_if.tag_id        = '0;
    in_if.button_code   = '0;
    in_if.control_word  = '0;
    in_if.epoch_count   = '0;
    in_if.expected_word = '0;

    dir_rows = '{
      // all-zero key and data give an all-zero register and auth word
      '{48'h0, 32'h0, 4'h0, 10'h000, 18'h00000, 32'h00000000, 0, 1, 32'h0, 1'b1},
      '{48'h0, 32'h0, 4'h0, 10'h000, 18'h00000, 32'hFFFFFFFF, 0, 1, 32'h0, 1'b0},
      '{48'h0, 32'hFFFFFFFF, 4'hF, 10'h3FF, 18'h3FFFF, 32'h0, 1, 0, 32'h0, 1'b0},
      '{48'h0, 32'hFFFFFFFF, 4'hF, 10'h3FF, 18'h3FFFF, 32'hFFFFFFFF, 0, 0, 32'h0, 1'b0},
      '{48'h0, 32'h0, 4'hF, 10'h000, 18'h00000, 32'h0, 0, 0, 32'h0, 1'b0},
      '{48'h0, 32'h0, 4'h0, 10'h3FF, 18'h00000, 32'h0, 0, 0, 32'h0, 1'b0},
      '{48'h0, 32'h0, 4'h0, 10'h000, 18'h3FFFF, 32'h0, 0, 0, 32'h0, 1'b0},
      '{48'h0, 32'h80000000, 4'h1, 10'h200, 18'h20000, 32'h0, 1, 0, 32'h0, 1'b0},
      '{48'hFFFFFFFFFFFF, 32'h0, 4'h0, 10'h000, 18'h00000, 32'h0, 0, 0, 32'h0, 1'b0},
      '{48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 4'hF, 10'h3FF, 18'h3FFFF, 32'h0, 1, 0, 32'h0, 1'b0},
      '{48'hFFFFFFFFFFFF, 32'h00000001, 4'h8, 10'h001, 18'h00001, 32'hFFFFFFFF, 0, 0,
        32'h0, 1'b0},
      '{48'hFFFFFFFFFFFF, 32'h12345678, 4'h5, 10'h2AA, 18'h15555, 32'h0, 1, 0, 32'h0, 1'b0},
      '{48'h800000000000, 32'h0, 4'h0, 10'h000, 18'h00000, 32'h0, 1, 0, 32'h0, 1'b0},
      '{48'h800000000000, 32'hFFFFFFFF, 4'hF, 10'h3FF, 18'h3FFFF, 32'h0, 0, 0, 32'h0, 1'b0},
      '{48'h000000000001, 32'h0, 4'h0, 10'h000, 18'h00000, 32'h0, 1, 0, 32'h0, 1'b0},
      '{48'h000000000001, 32'hA5A5A5A5, 4'h3, 10'h0F0, 18'h0F0F0, 32'h0, 0, 0, 32'h0, 1'b0},
      '{48'h5A5AC3C30FF0, 32'hDEADBEEF, 4'hA, 10'h155, 18'h2AAAA, 32'h0, 1, 0, 32'h0, 1'b0},
      '{48'h5A5AC3C30FF0, 32'hDEADBEEF, 4'hA, 10'h155, 18'h2AAAA, 32'h0BADF00D, 0, 0,
        32'h0, 1'b0},
      '{48'h5A5AC3C30FF0, 32'h0, 4'hF, 10'h3FF, 18'h3FFFF, 32'h0, 1, 0, 32'h0, 1'b0}
    };

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table, no idling
    for (int i = 0; i < NumRows; i++) begin
      if (i == 0 || dir_rows[i].key != cur_key) begin
        settle();
        load_key(dir_rows[i].key);
      end
      c.tag     = dir_rows[i].tag;
      c.button  = dir_rows[i].button;
      c.control = dir_rows[i].control;
      c.epoch   = dir_rows[i].epoch;
      c.rx_word = dir_rows[i].rx_word;
      if (dir_rows[i].hit) begin
        gold      = hop_auth(cur_key, c);
        c.rx_word = gold.auth;
      end
      if (dir_rows[i].typed_in) begin
        gold.auth    = dir_rows[i].typed_auth;
        gold.matched = dir_rows[i].typed_match;
      end else begin
        gold = hop_auth(cur_key, c);
      end
      push_word(c, gold);
    end

    // random candidates under four flow-control profiles
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      rkey = {$urandom, $urandom};
      load_key(rkey[47:0]);
      for (int n = 0; n < PhaseWords; n++) begin
        c.tag     = $urandom;
        c.button  = 4'($urandom_range(15));
        c.control = 10'($urandom_range(1023));
        c.epoch   = 18'($urandom_range(262143));
        c.rx_word = $urandom;
        pick = $urandom_range(7);
        gold = hop_auth(cur_key, c);
        // bias toward real hop words and near misses to exercise the compare
        if (pick < 2) c.rx_word = gold.auth;
        else if (pick == 2)
          c.rx_word = gold.auth ^ (32'h1 << $urandom_range(31));
        push_word(c, hop_auth(cur_key, c));
      end
    end

    in_if.valid = 1'b0;
    while (auth_q.size() != 0) @(posedge clk_i);
    repeat (ChainLat + 8) @(posedge clk_i);

    $display("Sent %0d candidates under %0d keys, checked %0d auth words (%0d matching).",
             words_sent, keys_loaded, words_checked, hits_seen);
    $display("Flow control: none, sender idle, receiver stall, and both mixed.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/nca_pkg.sv
rtl/core/nca_in_if.sv
rtl/core/nca_out_if.sv
rtl/core/nca_init_cell.sv
rtl/core/nca_out_cell.sv
rtl/core/nlfsr_cipher_auth_word_core.sv
tb/tb_nlfsr_cipher_auth_word_core.sv
